### rtl/core/msp_pkg.sv
package msp_pkg;

   localparam int MAX_STACKS_DEF = 16;
   localparam int POOL_DEPTH_DEF = 64;

   localparam int CMD_W   = 2;
   localparam int SN_W    = 5;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int LINK_W  = 7;

   localparam logic [LINK_W-1:0] NULL_LINK = '1;
   localparam logic [SN_W-1:0] STACKS_RESET = SN_W'(16);

   localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_DISPLAY = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [LINK_W-1:0]  next;
   } node_word_type;

endpackage

### rtl/core/msp_ram.sv
module msp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/multi_stack_shared_pool.sv
// A result word is registered in the state after the accept (PUSH_RD, POP_RD, PEEK_RD,
// WALK or RESP) once the output is free. Push, pop, peek and rejected commands pass
// through the accept state, then one state that uses the node memory read data (or the
// held status) and writes back on a pop or a free-list push; display gives one word per
// cycle while the output is not stalled (one node memory read per element).
// Reset: synchronous; all stacks empty, free list empty, no node allocated,
// stacks_in_use back to 16. The node memory is not cleared.
module multi_stack_shared_pool #(
   parameter int MAX_STACKS = msp_pkg::MAX_STACKS_DEF,
   parameter int POOL_DEPTH = msp_pkg::POOL_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // command[1:0], stack_number[6:2], push_value[38:7]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status[1:0], result_value[33:2]
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data  // stacks_in_use
);

   localparam int NODE_W = $clog2(POOL_DEPTH);
   localparam int SIDX_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
   localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
   localparam int LINK_W = msp_pkg::LINK_W;

   typedef enum logic [2:0] {
      IDLE, PUSH_RD, POP_RD, PEEK_RD, WALK, RESP
   } state_type;

   state_type                      state_ff, state_in;
   logic [msp_pkg::SN_W-1:0]       stacks_ff, stacks_in;
   logic [NODE_W-1:0]              top_link_ff [MAX_STACKS];
   logic [NODE_W-1:0]              top_link_in [MAX_STACKS];
   logic [MAX_STACKS-1:0]          top_valid_ff, top_valid_in;
   logic [LINK_W-1:0]              free_head_ff, free_head_in;
   logic [LINK_W-1:0]              fresh_ff, fresh_in;
   logic [msp_pkg::CMD_W-1:0]      cmd_ff, cmd_in;
   logic [SIDX_W-1:0]              sidx_ff, sidx_in;
   logic [msp_pkg::VALUE_W-1:0]    val_ff, val_in;
   logic [NODE_W-1:0]              node_ff, node_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [msp_pkg::STAT_W-1:0]     pend_status_ff, pend_status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [msp_pkg::STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [msp_pkg::VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           ram_wr_en, ram_rd_en;
   logic [NODE_W-1:0]              ram_wr_addr, ram_rd_addr;
   msp_pkg::node_word_type         ram_wr_data, ram_rd_data;

   logic [msp_pkg::CMD_W-1:0]      req_cmd;
   logic [msp_pkg::SN_W-1:0]       req_sn;
   logic [msp_pkg::VALUE_W-1:0]    req_val;
   logic [SIDX_W-1:0]              req_sidx;
   logic                           req_bad, free_ok, fresh_ok, out_free, nx_ok, walk_end;
   logic [LINK_W-1:0]              top_as_link;

   assign req_cmd  = req_tdata[1:0];
   assign req_sn   = req_tdata[6:2];
   assign req_val  = req_tdata[38:7];
   assign req_sidx = SIDX_W'(req_sn - msp_pkg::SN_W'(1));
   assign req_bad  = (req_sn == '0) || (req_sn > stacks_ff) ||
                     (req_sn > msp_pkg::SN_W'(MAX_STACKS));
   assign free_ok  = free_head_ff < LINK_W'(POOL_DEPTH);
   assign fresh_ok = fresh_ff < LINK_W'(POOL_DEPTH);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign nx_ok    = ram_rd_data.next < LINK_W'(POOL_DEPTH);
   assign walk_end = !nx_ok || (count_ff == CNT_W'(POOL_DEPTH - 1));
   assign top_as_link = top_valid_ff[sidx_ff] ? LINK_W'(top_link_ff[sidx_ff])
                                              : msp_pkg::NULL_LINK;

   assign req_tready = (state_ff == IDLE);

   always_comb begin
      state_in       = state_ff;
      stacks_in      = csr_wr_en ? csr_wr_data : stacks_ff;
      top_link_in    = top_link_ff;
      top_valid_in   = top_valid_ff;
      free_head_in   = free_head_ff;
      fresh_in       = fresh_ff;
      cmd_in         = cmd_ff;
      sidx_in        = sidx_ff;
      val_in         = val_ff;
      node_in        = node_ff;
      count_in       = count_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_last_in    = rsp_last_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = node_ff;
      ram_wr_data    = '0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = node_ff;

      case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_cmd;
               sidx_in  = req_sidx;
               val_in   = req_val;
               count_in = '0;
               state_in = RESP;
               if (req_bad) begin
                  pend_status_in = msp_pkg::ST_INVALID;
               end else if (req_cmd == msp_pkg::CMD_PUSH) begin
                  if (free_ok) begin
                     node_in     = free_head_ff[NODE_W-1:0];
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = free_head_ff[NODE_W-1:0];
                     state_in    = PUSH_RD;
                  end else if (fresh_ok) begin
                     ram_wr_en          = 1'b1;
                     ram_wr_addr        = fresh_ff[NODE_W-1:0];
                     ram_wr_data.value  = req_val;
                     ram_wr_data.next   = top_valid_ff[req_sidx] ?
                                          LINK_W'(top_link_ff[req_sidx]) : msp_pkg::NULL_LINK;
                     top_link_in[req_sidx]  = fresh_ff[NODE_W-1:0];
                     top_valid_in[req_sidx] = 1'b1;
                     fresh_in       = fresh_ff + LINK_W'(1);
                     pend_status_in = msp_pkg::ST_OK;
                  end else begin
                     pend_status_in = msp_pkg::ST_FULL;
                  end
               end else if (!top_valid_ff[req_sidx]) begin
                  pend_status_in = msp_pkg::ST_EMPTY;
               end else begin
                  node_in     = top_link_ff[req_sidx];
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = top_link_ff[req_sidx];
                  case (req_cmd)
                     msp_pkg::CMD_POP:  state_in = POP_RD;
                     msp_pkg::CMD_PEEK: state_in = PEEK_RD;
                     default:           state_in = WALK;
                  endcase
               end
            end
         end
         PUSH_RD: begin
            if (out_free) begin
               ram_wr_en            = 1'b1;
               ram_wr_data.value    = val_ff;
               ram_wr_data.next     = top_as_link;
               free_head_in         = ram_rd_data.next;
               top_link_in[sidx_ff]  = node_ff;
               top_valid_in[sidx_ff] = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = msp_pkg::ST_OK;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = IDLE;
            end
         end
         POP_RD: begin
            if (out_free) begin
               if (nx_ok) begin
                  top_link_in[sidx_ff] = ram_rd_data.next[NODE_W-1:0];
               end else begin
                  top_valid_in[sidx_ff] = 1'b0;
               end
               ram_wr_en         = 1'b1;
               ram_wr_data.value = ram_rd_data.value;
               ram_wr_data.next  = free_head_ff;
               free_head_in      = LINK_W'(node_ff);
               rsp_valid_in  = 1'b1;
               rsp_status_in = msp_pkg::ST_OK;
               rsp_value_in  = ram_rd_data.value;
               rsp_last_in   = 1'b1;
               state_in      = IDLE;
            end
         end
         PEEK_RD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = msp_pkg::ST_OK;
               rsp_value_in  = ram_rd_data.value;
               rsp_last_in   = 1'b1;
               state_in      = IDLE;
            end
         end
         WALK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = msp_pkg::ST_OK;
               rsp_value_in  = ram_rd_data.value;
               rsp_last_in   = walk_end;
               if (walk_end) begin
                  state_in = IDLE;
               end else begin
                  node_in     = ram_rd_data.next[NODE_W-1:0];
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ram_rd_data.next[NODE_W-1:0];
                  count_in    = count_ff + CNT_W'(1);
               end
            end
         end
         RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      top_link_ff    <= top_link_in;
      cmd_ff         <= cmd_in;
      sidx_ff        <= sidx_in;
      val_ff         <= val_in;
      node_ff        <= node_in;
      count_ff       <= count_in;
      pend_status_ff <= pend_status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_last_ff    <= rsp_last_in;
      if (reset) begin
         state_ff     <= IDLE;
         stacks_ff    <= msp_pkg::STACKS_RESET;
         top_valid_ff <= '0;
         free_head_ff <= msp_pkg::NULL_LINK;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stacks_ff    <= stacks_in;
         top_valid_ff <= top_valid_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   msp_ram #(
      .WIDTH ($bits(msp_pkg::node_word_type)),
      .DEPTH (POOL_DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_value_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_free_head_range: assert property (@(posedge clock) disable iff (reset)
      free_ok || (free_head_ff == msp_pkg::NULL_LINK))
      else $error("free list head out of range");

   a_fresh_range: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= LINK_W'(POOL_DEPTH))
      else $error("fresh count past pool depth");

   a_invalid_resp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_bad) |=>
         (state_ff == RESP) && (pend_status_ff == msp_pkg::ST_INVALID))
      else $error("invalid stack number not rejected");

   a_partial_is_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (cmd_ff == msp_pkg::CMD_DISPLAY) && (state_ff == WALK))
      else $error("non-final word outside a display walk");

   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == WALK) |-> !ram_wr_en)
      else $error("node memory written during a walk");

endmodule
